>>> hdl/bfs_augmenting_max_flow_assert.svh
// Assertion helpers for the max-flow block.
`ifndef BFS_AUGMENTING_MAX_FLOW_ASSERT_SVH
`define BFS_AUGMENTING_MAX_FLOW_ASSERT_SVH

// Same-cycle implication, held off while in reset.
`define BAM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while in reset.
`define BAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bam_pkg.sv
package bam_pkg;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_SOLVE = 2'd2;

    localparam logic [1:0] CFG_VERTEX_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_VERTEX = 2'd1;
    localparam logic [1:0] CFG_SINK_VERTEX   = 2'd2;

    localparam logic [31:0] NO_LIMIT = 32'hFFFF_FFFF;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? NO_LIMIT : s[31:0];
    endfunction

endpackage

>>> hdl/bam_ram.sv
module bam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/bfs_augmenting_max_flow.sv
// Edmonds-Karp maximum flow over a residual matrix held in one synchronous RAM of
// 2**(2*VW) words (VW = clog2(MAX_VERTICES)), addressed {from, to}. Items: clear (action 0),
// add edge (action 1: read then saturating write back) and solve (action 2).
// After reset and after each clear item the matrix is swept to zero one word a cycle,
// all 2**(2*VW) words (4096 at 64 vertices), and no item is taken meanwhile; config writes are
// always taken. A solve runs breadth-first searches until none reaches the sink. Each search
// starts by seeding the source, then for each dequeued vertex reads its queue entry and its
// bottleneck and scans its neighbours with one residual read each; each path found does two
// read-modify-writes per path edge, on the forward and reverse entries, then adds its flow.
// Parent/bottleneck and the search queue live in small RAMs of their own. The result sits in
// an output register, so the next item is taken while the result beat waits; a solve
// finishing while an older result is still stalled waits for it to go. Degenerate
// terminals return the running flow with no search.
module bfs_augmenting_max_flow #(
    parameter int MAX_VERTICES = 64,
    parameter int CAP_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_from_vertex,
    input  logic [5:0]  i_to_vertex,
    input  logic [15:0] i_edge_capacity,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_total_flow,
    output logic [15:0] o_path_count,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bam_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);       // vertex index bits
    localparam int CW = $clog2(MAX_VERTICES + 1);   // vertex count bits
    localparam int AW = 2 * VW;                     // residual address bits
    localparam int RES_DEPTH = 1 << AW;
    localparam int PBW = VW + 32;                   // {parent, bottleneck}
    localparam logic [31:0] CAP_MASK = 32'((64'd1 << CAP_BITS) - 64'd1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD, S_BFS_INIT, S_POP, S_POP_W, S_POP_B,
        S_SCAN, S_EVAL, S_BT_RDP, S_BT_P, S_BT_FW, S_BT_RV, S_AUG_END, S_DONE
    } t_state;

    t_state r_state;

    // config
    logic [6:0] r_vertex_count;
    logic [5:0] r_source_vertex;
    logic [5:0] r_sink_vertex;

    // working registers
    logic [AW-1:0]           r_clr_addr;
    logic [AW-1:0]           r_add_addr;
    logic [31:0]             r_cap;
    logic [CW-1:0]           r_n;
    logic [VW-1:0]           r_src;
    logic [VW-1:0]           r_dst;
    logic [CW-1:0]           r_head;
    logic [CW-1:0]           r_tail;
    logic [VW-1:0]           r_u;
    logic [31:0]             r_bu;
    logic [VW-1:0]           r_v;
    logic [VW-1:0]           r_w;
    logic [VW-1:0]           r_p;
    logic [31:0]             r_f;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [31:0]             r_flow;
    logic [15:0]             r_paths;
    logic                    r_ovalid;
    logic [31:0]             r_total_out;
    logic [15:0]             r_paths_out;

    // memory ports
    logic          res_we;
    logic [AW-1:0] res_waddr, res_raddr;
    logic [31:0]   res_wdata, res_rdata;
    logic          pb_we;
    logic [VW-1:0] pb_waddr, pb_raddr;
    logic [PBW-1:0] pb_wdata, pb_rdata;
    logic          q_we;
    logic [VW-1:0] q_waddr, q_raddr;
    logic [VW-1:0] q_wdata, q_rdata;

    logic          in_acc;
    logic [CW-1:0] w_n;
    logic          w_edge_ok;
    logic          w_term_ok;
    logic          w_new;      // neighbour reached for the first time
    logic [31:0]   w_bmin;
    logic          w_last_v;

    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_total_flow = r_total_out;
    assign o_path_count = r_paths_out;

    assign w_n = (32'(r_vertex_count) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                          : CW'(r_vertex_count);
    assign w_edge_ok = (32'(i_from_vertex) < 32'(MAX_VERTICES)) &&
                       (32'(i_to_vertex) < 32'(MAX_VERTICES));
    assign w_term_ok = (32'(r_source_vertex) < 32'(w_n)) && (32'(r_sink_vertex) < 32'(w_n)) &&
                       (r_source_vertex != r_sink_vertex);
    assign w_new    = !r_visited[r_v] && (res_rdata != 32'd0);
    assign w_bmin   = (res_rdata < r_bu) ? res_rdata : r_bu;
    assign w_last_v = ((CW'(r_v) + CW'(1)) == r_n);

    // memory control
    always_comb begin
        res_we    = 1'b0;
        res_waddr = r_clr_addr;
        res_wdata = 32'd0;
        res_raddr = {r_u, r_v};
        pb_we     = 1'b0;
        pb_waddr  = r_v;
        pb_wdata  = {r_u, w_bmin};
        pb_raddr  = r_w;
        q_we      = 1'b0;
        q_waddr   = r_tail[VW-1:0];
        q_wdata   = r_v;
        q_raddr   = r_head[VW-1:0];
        case (r_state)
            S_CLEAR: begin
                res_we = 1'b1;
            end
            S_IDLE: begin
                res_raddr = {VW'(i_from_vertex), VW'(i_to_vertex)};
            end
            S_ADD: begin
                res_we    = 1'b1;
                res_waddr = r_add_addr;
                res_wdata = sat_add32(res_rdata, r_cap);
            end
            S_BFS_INIT: begin
                pb_we    = 1'b1;
                pb_waddr = r_src;
                pb_wdata = {r_src, NO_LIMIT};
                q_we     = 1'b1;
                q_waddr  = '0;
                q_wdata  = r_src;
            end
            S_POP_W: begin
                pb_raddr = q_rdata;
            end
            S_EVAL: begin
                pb_we = w_new;
                q_we  = w_new && (r_v != r_dst) && (32'(r_tail) < 32'(MAX_VERTICES));
            end
            S_BT_P: begin
                res_raddr = {pb_rdata[PBW-1:32], r_w};
            end
            S_BT_FW: begin
                res_we    = 1'b1;
                res_waddr = {r_p, r_w};
                res_wdata = res_rdata - r_f;
                res_raddr = {r_w, r_p};
            end
            S_BT_RV: begin
                res_we    = 1'b1;
                res_waddr = {r_w, r_p};
                res_wdata = sat_add32(res_rdata, r_f);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_addr      <= '0;
            r_flow          <= '0;
            r_visited       <= '0;
            r_ovalid        <= 1'b0;
            r_head          <= '0;
            r_tail          <= '0;
            r_vertex_count  <= 7'd64;
            r_source_vertex <= 6'd0;
            r_sink_vertex   <= 6'd1;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VERTEX_COUNT:  r_vertex_count  <= i_cfg_data[6:0];
                    CFG_SOURCE_VERTEX: r_source_vertex <= i_cfg_data[5:0];
                    CFG_SINK_VERTEX:   r_sink_vertex   <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            // a finishing solve reloads the output register itself
            if (r_ovalid && !i_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (32'(r_clr_addr) == RES_DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_action)
                            ACT_CLEAR: begin
                                r_flow     <= '0;
                                r_visited  <= '0;
                                r_clr_addr <= '0;
                                r_state    <= S_CLEAR;
                            end
                            ACT_ADD: begin
                                r_add_addr <= {VW'(i_from_vertex), VW'(i_to_vertex)};
                                r_cap      <= 32'(i_edge_capacity) & CAP_MASK;
                                if (w_edge_ok) begin
                                    r_state <= S_ADD;
                                end
                            end
                            ACT_SOLVE: begin
                                r_n     <= w_n;
                                r_src   <= VW'(r_source_vertex);
                                r_dst   <= VW'(r_sink_vertex);
                                r_paths <= '0;
                                r_state <= w_term_ok ? S_BFS_INIT : S_DONE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    r_state <= S_IDLE;
                end
                S_BFS_INIT: begin
                    r_visited <= MAX_VERTICES'(1) << r_src;   // only the source seen
                    r_head    <= '0;
                    r_tail    <= CW'(1);
                    r_state   <= S_POP;
                end
                S_POP: begin
                    if (r_head < r_tail) begin
                        r_head  <= r_head + CW'(1);
                        r_state <= S_POP_W;
                    end else begin
                        r_state <= S_DONE;   // no path left
                    end
                end
                S_POP_W: begin
                    r_u     <= q_rdata;
                    r_state <= S_POP_B;
                end
                S_POP_B: begin
                    r_bu    <= pb_rdata[31:0];
                    r_v     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_new) begin
                        r_visited[r_v] <= 1'b1;
                    end
                    if (w_new && (r_v == r_dst)) begin
                        r_f     <= w_bmin;
                        r_w     <= r_v;
                        r_state <= S_BT_RDP;
                    end else begin
                        if (w_new && (32'(r_tail) < 32'(MAX_VERTICES))) begin
                            r_tail <= r_tail + CW'(1);
                        end
                        r_v     <= r_v + VW'(1);
                        r_state <= w_last_v ? S_POP : S_SCAN;
                    end
                end
                S_BT_RDP: begin
                    r_state <= S_BT_P;
                end
                S_BT_P: begin
                    r_p     <= pb_rdata[PBW-1:32];
                    r_state <= S_BT_FW;
                end
                S_BT_FW: begin
                    r_state <= S_BT_RV;
                end
                S_BT_RV: begin
                    r_w     <= r_p;
                    r_state <= (r_p == r_src) ? S_AUG_END : S_BT_RDP;
                end
                S_AUG_END: begin
                    r_flow <= sat_add32(r_flow, r_f);
                    if (r_paths != 16'hFFFF) begin
                        r_paths <= r_paths + 16'd1;
                    end
                    r_state <= S_BFS_INIT;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid    <= 1'b1;
                        r_total_out <= r_flow;
                        r_paths_out <= r_paths;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bam_ram #(.WIDTH(32), .DEPTH(RES_DEPTH)) u_residual (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_raddr (res_raddr),
        .o_rdata (res_rdata)
    );

    bam_ram #(.WIDTH(PBW), .DEPTH(1 << VW)) u_parent (
        .i_clk   (i_clk),
        .i_we    (pb_we),
        .i_waddr (pb_waddr),
        .i_wdata (pb_wdata),
        .i_raddr (pb_raddr),
        .o_rdata (pb_rdata)
    );

    bam_ram #(.WIDTH(VW), .DEPTH(1 << VW)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

`include "bfs_augmenting_max_flow_assert.svh"

    // queue never runs past one slot per vertex
    `BAM_ASSERT_NOW(a_tail_bound, 1'b1, 32'(r_tail) <= MAX_VERTICES, "queue tail overrun")
    // a dequeue only happens with an entry waiting
    `BAM_ASSERT_NOW(a_pop_nonempty, r_state == S_POP_W, r_head <= r_tail, "dequeue from empty")
    // forward and reverse residual entries of one path edge never coincide
    `BAM_ASSERT_NOW(a_bt_distinct, r_state == S_BT_FW, r_p != r_w, "path edge is a self loop")
    // a finished solve hands its result to the output register
    `BAM_ASSERT_NEXT(a_done_out, (r_state == S_DONE) && !r_ovalid, r_ovalid, "result lost")

endmodule

>>> tb/tb_bfs_augmenting_max_flow.sv
`default_nettype none

module tb_bfs_augmenting_max_flow;
    timeunit 1ns;
    timeprecision 1ps;

    import bam_pkg::*;

    // action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // unused register index, writes to it change nothing
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int NV = 64;
    localparam int RANDOM_ITEMS = 1800;
    // quiet-cycle limit: large enough to cover a long 64-vertex solve
    localparam int QUIET_LIMIT = 1_500_000;
    // settle time before a register write, so a pending add-edge read-modify-write finishes
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [31:0] flow;
        logic [15:0] paths;
    } t_flow_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [5:0]  i_from_vertex;
    logic [5:0]  i_to_vertex;
    logic [15:0] i_edge_capacity;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_total_flow;
    logic [15:0] o_path_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    bfs_augmenting_max_flow u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_from_vertex   (i_from_vertex),
        .i_to_vertex     (i_to_vertex),
        .i_edge_capacity (i_edge_capacity),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_total_flow    (o_total_flow),
        .o_path_count    (o_path_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // starts low so that no rising edge falls at time zero
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ---------------------------------------------------------------
    // Predictor state: residual matrix, running flow and the registers
    // ---------------------------------------------------------------
    logic [31:0] resid [NV][NV];
    logic [31:0] flow_total;
    logic [6:0]  cfg_vertices;
    logic [5:0]  cfg_source;
    logic [5:0]  cfg_sink;

    t_flow_result flow_expected[$];
    t_flow_result got;
    int mismatches;
    int burst_left;
    int random_items;
    int quiet_cycles;
    logic [11:0] stall_phase;

    function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] s;
        s = a + b;
        return (s < a) ? 32'hFFFF_FFFF : s;
    endfunction

    // One breadth-first search, neighbours in rising index order. The path is
    // committed as soon as the sink is first reached; returns its bottleneck.
    function automatic logic [31:0] augment_path(input int n, input int src, input int dst);
        bit          seen [NV];
        int          came_from [NV];
        logic [31:0] lim [NV];
        int          fifo [NV];
        int          head;
        int          tail;
        int          u;
        int          w;
        int          p;
        head = 0;
        tail = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        seen[src] = 1'b1;
        came_from[src] = src;
        lim[src] = 32'hFFFF_FFFF;   // no limit at the source
        fifo[tail] = src;
        tail++;
        while (head < tail) begin
            u = fifo[head];
            head++;
            for (int v = 0; v < n; v++) begin
                if (seen[v] || resid[u][v] == 0)
                    continue;
                seen[v] = 1'b1;
                came_from[v] = u;
                lim[v] = (resid[u][v] < lim[u]) ? resid[u][v] : lim[u];
                if (v == dst) begin
                    w = v;
                    while (w != src) begin
                        p = came_from[w];
                        resid[p][w] = resid[p][w] - lim[dst];
                        resid[w][p] = sat32(resid[w][p], lim[dst]);
                        w = p;
                    end
                    return lim[dst];
                end
                if (tail < NV) begin
                    fifo[tail] = v;
                    tail++;
                end
            end
        end
        return 32'd0;
    endfunction

    function automatic t_flow_result solve_flow();
        t_flow_result res;
        int           n;
        logic [31:0]  f;
        logic [15:0]  paths;
        n = (int'(cfg_vertices) > NV) ? NV : int'(cfg_vertices);
        paths = '0;
        if (int'(cfg_source) < n && int'(cfg_sink) < n && cfg_source != cfg_sink) begin
            f = augment_path(n, cfg_source, cfg_sink);
            while (f != 0) begin
                flow_total = sat32(flow_total, f);
                if (paths != 16'hFFFF)
                    paths++;
                f = augment_path(n, cfg_source, cfg_sink);
            end
        end
        res.flow  = flow_total;
        res.paths = paths;
        return res;
    endfunction

    function automatic void apply_beat(input logic [1:0] act, input logic [5:0] from_v,
                                       input logic [5:0] to_v, input logic [15:0] cap);
        case (act)
            ACT_CLEAR: begin
                foreach (resid[a, b]) resid[a][b] = '0;
                flow_total = '0;
            end
            ACT_ADD:   resid[from_v][to_v] = sat32(resid[from_v][to_v], {16'd0, cap});
            ACT_SOLVE: flow_expected.insert(flow_expected.size(), solve_flow());
            default:   ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Item sender: bursts of random length, random gaps between them.
    // valid stays high across a burst; it is lowered only for a gap or an idle wait.
    // ---------------------------------------------------------------
    task automatic send_beat(input logic [1:0] act, input logic [5:0] from_v,
                             input logic [5:0] to_v, input logic [15:0] cap);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_action        <= act;
        i_from_vertex   <= from_v;
        i_to_vertex     <= to_v;
        i_edge_capacity <= cap;
        do @(posedge i_clk); while (o_stall);
        apply_beat(act, from_v, to_v, cap);
    endtask

    task automatic send_edge(input int from_v, input int to_v, input int cap);
        send_beat(ACT_ADD, from_v[5:0], to_v[5:0], cap[15:0]);
    endtask

    task automatic send_solve();
        send_beat(ACT_SOLVE, 6'($urandom), 6'($urandom), 16'($urandom));
    endtask

    // Drop valid, drain every pending result, then let an add-edge settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (flow_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; valid is dropped right after the beat so a following
    // write raises it in a later time step.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VERTEX_COUNT:  cfg_vertices = data[6:0];
            CFG_SOURCE_VERTEX: cfg_source   = data[5:0];
            CFG_SINK_VERTEX:   cfg_sink     = data[5:0];
            default:           ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_flow_result want,
                                 input t_flow_result seen);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected flow %0d paths %0d, got flow %0d paths %0d",
                     $realtime, what, want.flow, want.paths, seen.flow, seen.paths);
    endtask

    // ---------------------------------------------------------------
    // Result side: own stall pattern, and the check of each beat
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_phase <= '0;
            i_stall     <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1'b1;
            case (stall_phase[11:10])
                2'd0:    i_stall <= 1'b0;                         // no back-pressure
                2'd1:    i_stall <= ($urandom_range(0, 3) == 0);
                2'd2:    i_stall <= stall_phase[3];               // square wave
                default: i_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got.flow  = o_total_flow;
            got.paths = o_path_count;
            if (flow_expected.size() == 0)
                note_mismatch("unexpected result", '0, got);
            else if (flow_expected[0] !== got)
                note_mismatch("result mismatch", flow_expected.pop_front(), got);
            else
                void'(flow_expected.pop_front());
        end
    end

    // Watchdog: counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bfs_augmenting_max_flow: mismatch");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Empty graph, parallel and zero edges, self loop, far vertex, ignored
    // action, degenerate terminals, oversized vertex count, clear.
    task automatic test_directed();
        send_solve();
        send_edge(0, 1, 16'hFFFF);
        send_edge(0, 1, 1);
        send_edge(0, 1, 0);
        send_edge(5, 5, 9);
        send_edge(0, 2, 16'hAAAA);
        send_edge(2, 1, 16'h5555);
        send_edge(0, 63, 7);
        send_edge(63, 1, 16'hFFFF);
        send_beat(ACT_UNUSED, 6'h3F, 6'h2A, 16'hFFFF);
        send_solve();
        send_solve();           // nothing left to push
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, 32'd2);
        send_edge(0, 1, 16'h8000);
        send_edge(0, 40, 5);    // touches an unused vertex
        send_solve();
        wait_idle();
        write_reg(CFG_SOURCE_VERTEX, 32'd1);
        send_solve();           // source equals sink
        wait_idle();
        write_reg(CFG_SOURCE_VERTEX, 32'd63);
        send_solve();           // source beyond the vertex count
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, 32'd0);
        write_reg(CFG_SOURCE_VERTEX, 32'd0);
        send_solve();
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, 32'd127);
        write_reg(CFG_SINK_VERTEX, 32'd63);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_edge(0, 63, 16'h1234);
        send_solve();
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, 32'd100);
        send_beat(ACT_CLEAR, 6'h3F, 6'h3F, 16'hFFFF);
        send_solve();
        wait_idle();
    endtask

    task automatic test_random_graphs();
        int kind;
        int nv;
        int live;
        int edges;
        int rounds;
        int pick;
        int cap;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            kind = $urandom_range(0, 19);
            if (kind == 0)      nv = 64;
            else if (kind == 1) nv = $urandom_range(65, 127);
            else                nv = $urandom_range(2, 10);
            live = (nv > NV) ? NV : nv;
            // upper data bits are don't-care, so scramble them at times
            write_reg(CFG_VERTEX_COUNT, {($urandom_range(0, 3) == 0) ? 25'($urandom) : 25'd0,
                                         7'(nv)});
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_SOURCE_VERTEX, $urandom);
                write_reg(CFG_SINK_VERTEX, $urandom);
            end else begin
                pick = $urandom_range(0, live - 1);
                write_reg(CFG_SOURCE_VERTEX, pick);
                write_reg(CFG_SINK_VERTEX, (pick + $urandom_range(1, live - 1)) % live);
            end
            if (kind < 2 || $urandom_range(0, 2) == 0) begin
                send_beat(ACT_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
                random_items++;
            end
            rounds = $urandom_range(1, 3);
            repeat (rounds) begin
                edges = $urandom_range(2, (3 * live > 40) ? 40 : 3 * live);
                repeat (edges) begin
                    case ($urandom_range(0, 3))
                        0:       cap = $urandom_range(1, 20);
                        1:       cap = $urandom_range(0, 16'hFFFF);
                        2:       cap = 16'hFFFF;
                        default: cap = $urandom_range(0, 3);
                    endcase
                    if ($urandom_range(0, 15) == 0)
                        send_beat(ACT_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom));
                    else if ($urandom_range(0, 9) == 0)
                        send_edge($urandom_range(0, 63), $urandom_range(0, 63), cap);
                    else
                        send_edge($urandom_range(0, live - 1), $urandom_range(0, live - 1), cap);
                    random_items++;
                end
                send_solve();
                random_items++;
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_action        <= ACT_CLEAR;
        i_from_vertex   <= '0;
        i_to_vertex     <= '0;
        i_edge_capacity <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_VERTEX_COUNT;
        i_cfg_data      <= '0;
        mismatches      = 0;
        burst_left      = 0;
        random_items    = 0;
        foreach (resid[a, b]) resid[a][b] = '0;
        flow_total   = '0;
        cfg_vertices = 7'd64;
        cfg_source   = 6'd0;
        cfg_sink     = 6'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_graphs();

        // pending results were drained by the last idle wait; a little more
        // time catches any stray beat
        repeat (50) @(posedge i_clk);
        if (flow_expected.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", flow_expected.size());
        end
        if (mismatches == 0)
            $display("bfs_augmenting_max_flow: match");
        else
            $display("bfs_augmenting_max_flow: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
